/* hdl/kgd_pkg.sv */
package kgd_pkg;

  parameter int unsigned TIMER_BITS = 16;

  localparam int unsigned CFG_DATA_BITS = 16;
  localparam int unsigned CFG_ADDR_BITS = 2;

  localparam logic [7:0]  DEBOUNCE_TICKS_RST = 8'd5;
  localparam logic [15:0] CLICK_WINDOW_RST   = 16'd200;
  localparam logic [7:0]  CLICK_TARGET_RST   = 8'd3;
  localparam logic [15:0] LONG_TICKS_RST     = 16'd150;

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    REG_DEBOUNCE_TICKS = 2'd0,
    REG_CLICK_WINDOW   = 2'd1,
    REG_CLICK_TARGET   = 2'd2,
    REG_LONG_TICKS     = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    GEST_NONE  = 2'd0,
    GEST_LONG  = 2'd1,
    GEST_MULTI = 2'd2
  } gesture_e;

  typedef struct packed {
    logic [7:0]  debounce_ticks;
    logic [15:0] click_window;
    logic [7:0]  click_target;
    logic [15:0] long_ticks;
  } cfg_t;

endpackage

/* hdl/key_gesture_detector_core.sv */
// Key gesture detector: each input item is one scan tick of the raw, active-low key
// level, and each tick yields exactly one result item carrying the gesture event of
// that tick (none, long press or multi-click) and the most recent gesture seen. The
// whole tick is evaluated combinationally between the key state registers and the
// output register, so the block accepts one item per clock and a result appears in
// the cycle after its item; the output register stalls the input only while a
// result waits and the master side is not ready. Configuration must be written
// through the plain write port only while no tick is in flight, which the block
// does not enforce; TimerBits sets the width of the click window and hold timers.
module key_gesture_detector_core #(
  parameter int unsigned TimerBits = kgd_pkg::TIMER_BITS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [7:0]                         s_axis_tdata,  // [0] key_level
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [7:0]                         m_axis_tdata,  // [1:0] gesture_event, [3:2] last_gesture
  input  logic                               cfg_we_i,
  input  logic [kgd_pkg::CFG_ADDR_BITS-1:0]  cfg_addr_i,
  input  logic [kgd_pkg::CFG_DATA_BITS-1:0]  cfg_wdata_i
);

  kgd_pkg::cfg_t     cfg_q;
  kgd_pkg::gesture_e ev;
  kgd_pkg::gesture_e last;
  kgd_pkg::gesture_e ev_q;
  kgd_pkg::gesture_e last_q;
  logic              valid_q;
  logic              accept;

  assign s_axis_tready = !valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks <= kgd_pkg::DEBOUNCE_TICKS_RST;
      cfg_q.click_window   <= kgd_pkg::CLICK_WINDOW_RST;
      cfg_q.click_target   <= kgd_pkg::CLICK_TARGET_RST;
      cfg_q.long_ticks     <= kgd_pkg::LONG_TICKS_RST;
    end else if (cfg_we_i) begin
      case (kgd_pkg::cfg_reg_e'(cfg_addr_i))
        kgd_pkg::REG_DEBOUNCE_TICKS: cfg_q.debounce_ticks <= cfg_wdata_i[7:0];
        kgd_pkg::REG_CLICK_WINDOW:   cfg_q.click_window   <= cfg_wdata_i[15:0];
        kgd_pkg::REG_CLICK_TARGET:   cfg_q.click_target   <= cfg_wdata_i[7:0];
        kgd_pkg::REG_LONG_TICKS:     cfg_q.long_ticks     <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  kgd_tracker #(
    .TimerBits(TimerBits)
  ) u_tracker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (accept),
    .key_level_i(s_axis_tdata[0]),
    .cfg_i      (cfg_q),
    .event_o    (ev),
    .last_o     (last)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ev_q   <= ev;
      last_q <= last;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {4'b0000, last_q, ev_q};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid)
    else $error("Accepted item produced no result.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("Input stalled although the output register is empty.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[1:0] != kgd_pkg::GEST_NONE))
      |-> (m_axis_tdata[3:2] == m_axis_tdata[1:0]))
    else $error("Last gesture does not follow the event of the same item.");

endmodule

/* hdl/kgd_tracker.sv */
module kgd_tracker #(
  parameter int unsigned TimerBits = kgd_pkg::TIMER_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic              key_level_i,
  input  kgd_pkg::cfg_t     cfg_i,
  output kgd_pkg::gesture_e event_o,
  output kgd_pkg::gesture_e last_o
);

  localparam int unsigned CmpBits = (TimerBits > 16) ? TimerBits : 16;
  localparam logic [TimerBits-1:0] TimerMax = '1;

  logic                 stable_q, stable_d;
  logic [7:0]           dcnt_q, dcnt_d;
  logic                 armed_q, armed_d;
  logic [7:0]           tally_q, tally_d;
  logic [TimerBits-1:0] wt_q, wt_d;
  logic [TimerBits-1:0] hold_q, hold_d;
  logic                 long_q, long_d;
  kgd_pkg::gesture_e    latch_q, latch_d;
  kgd_pkg::gesture_e    ev;
  logic                 pressed;
  logic                 multi;
  logic                 longp;

  always_comb begin
    stable_d = stable_q;
    dcnt_d   = dcnt_q;
    armed_d  = armed_q;
    tally_d  = tally_q;
    wt_d     = wt_q;
    hold_d   = hold_q;
    long_d   = long_q;
    multi    = 1'b0;
    longp    = 1'b0;
    pressed  = ~key_level_i;
    if (pressed != stable_q) begin
      if (dcnt_q != 8'hFF) begin
        dcnt_d = dcnt_q + 8'd1;
      end
      if (dcnt_d > cfg_i.debounce_ticks) begin
        if (!pressed && !long_q) begin
          armed_d = 1'b1;
          if (tally_q != 8'hFF) begin
            tally_d = tally_q + 8'd1;
          end
        end
        stable_d = pressed;
      end
    end else begin
      dcnt_d = '0;
      if (armed_q && (CmpBits'(wt_q) <= CmpBits'(cfg_i.click_window))) begin
        if (wt_q != TimerMax) begin
          wt_d = wt_q + TimerBits'(1);
        end
        if (tally_q == cfg_i.click_target) begin
          armed_d = 1'b0;
          tally_d = '0;
          wt_d    = '0;
          multi   = 1'b1;
        end
      end else begin
        armed_d = 1'b0;
        tally_d = '0;
        wt_d    = '0;
      end
      if (stable_q) begin
        if ((CmpBits'(hold_q) <= CmpBits'(cfg_i.long_ticks)) && (hold_q != TimerMax)) begin
          hold_d = hold_q + TimerBits'(1);
          if (CmpBits'(hold_d) == CmpBits'(cfg_i.long_ticks)) begin
            long_d = 1'b1;
            longp  = 1'b1;
          end
        end
      end else begin
        long_d = 1'b0;
        hold_d = '0;
      end
    end
    if (longp) begin
      ev = kgd_pkg::GEST_LONG;
    end else if (multi) begin
      ev = kgd_pkg::GEST_MULTI;
    end else begin
      ev = kgd_pkg::GEST_NONE;
    end
    latch_d = (ev != kgd_pkg::GEST_NONE) ? ev : latch_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q <= 1'b0;
      dcnt_q   <= '0;
      armed_q  <= 1'b0;
      tally_q  <= '0;
      wt_q     <= '0;
      hold_q   <= '0;
      long_q   <= 1'b0;
      latch_q  <= kgd_pkg::GEST_NONE;
    end else if (step_i) begin
      stable_q <= stable_d;
      dcnt_q   <= dcnt_d;
      armed_q  <= armed_d;
      tally_q  <= tally_d;
      wt_q     <= wt_d;
      hold_q   <= hold_d;
      long_q   <= long_d;
      latch_q  <= latch_d;
    end
  end

  assign event_o = ev;
  assign last_o  = latch_d;

endmodule
